@@ hdl/rcsp_pkg.sv @@
// Shared types and character codes for the request stream parser.
package rcsp_pkg;

	typedef enum logic [2:0] {
		M_START,
		M_INLINE,
		M_COUNT,
		M_DOLLAR,
		M_LENGTH,
		M_DATA,
		M_DATA_CR
	} mode_t;

	typedef enum logic [1:0] {
		P_FIRST,
		P_DIGITS,
		P_CR
	} phase_t;

	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_MB_START  = 4'd1;
	localparam logic [3:0] EV_IN_START  = 4'd2;
	localparam logic [3:0] EV_DATA      = 4'd3;
	localparam logic [3:0] EV_ARG_END   = 4'd4;
	localparam logic [3:0] EV_ARG_CMD   = 4'd5;
	localparam logic [3:0] EV_CMD_END   = 4'd6;
	localparam logic [3:0] EV_ERROR     = 4'd7;
	localparam logic [3:0] EV_ARG_HDR   = 4'd8;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;

	typedef struct packed {
		mode_t        mode;
		phase_t       phase;
		logic [19:0]  accum;
		logic [15:0]  args_total;
		logic [15:0]  args_done;
		logic [19:0]  bytes_left;
		logic         word_open;
	} state_t;

	typedef struct packed {
		logic [19:0] count;
		logic [7:0]  data_byte;
		logic [3:0]  event_res;
	} result_t;

endpackage

@@ hdl/rcsp_step.sv @@
// Next-state and event logic for one request byte.
module rcsp_step import rcsp_pkg::*; #(
	parameter int MAX_ARGS    = 65535,
	parameter int MAX_ARG_LEN = 1048575
) (
	input  state_t       st,
	input  logic [7:0]   in_byte,
	output state_t       st_nxt,
	output result_t      res
);

	typedef enum logic [1:0] {
		N_MORE,
		N_DONE,
		N_FAIL
	} nres_t;

	localparam logic [23:0] ARGS_LIM = 24'(MAX_ARGS);
	localparam logic [23:0] LEN_LIM  = 24'(MAX_ARG_LEN);

	logic        is_digit;
	logic [3:0]  dval;
	logic [23:0] limit;
	logic [23:0] times_ten;
	logic [23:0] v;
	nres_t       nres;
	phase_t      num_phase;
	logic [19:0] num_accum;
	logic        is_letter;
	logic        is_space;
	logic [15:0] done_inc;

	assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign dval      = in_byte[3:0];
	assign limit     = (st.mode == M_COUNT) ? ARGS_LIM : LEN_LIM;
	assign times_ten = {1'b0, st.accum, 3'b000} + {3'b000, st.accum, 1'b0};
	assign v         = times_ten + {20'd0, dval};
	assign is_letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A))
		|| ((in_byte >= 8'h61) && (in_byte <= 8'h7A));
	assign is_space  = (in_byte == CH_SPACE) || (in_byte == CH_TAB)
		|| (in_byte == CH_VT) || (in_byte == CH_FF);
	assign done_inc  = st.args_done + 16'd1;

	always_comb begin
		nres      = N_FAIL;
		num_phase = P_FIRST;
		num_accum = st.accum;
		case (st.phase)
			P_FIRST: begin
				if (is_digit && (in_byte != CH_ZERO) && ({20'd0, dval} <= limit)) begin
					nres      = N_MORE;
					num_phase = P_DIGITS;
					num_accum = {16'd0, dval};
				end
			end
			P_DIGITS: begin
				if (is_digit) begin
					if (v <= limit) begin
						nres      = N_MORE;
						num_phase = P_DIGITS;
						num_accum = v[19:0];
					end
				end else if (in_byte == CH_CR) begin
					nres      = N_MORE;
					num_phase = P_CR;
				end else if (in_byte == CH_LF) begin
					nres = N_DONE;
				end
			end
			default: begin
				if (in_byte == CH_LF) begin
					nres = N_DONE;
				end
			end
		endcase
	end

	always_comb begin
		st_nxt        = st;
		res.event_res = EV_NONE;
		res.data_byte = 8'd0;
		res.count     = 20'd0;
		case (st.mode)
			M_START: begin
				if (in_byte == CH_STAR) begin
					st_nxt.mode  = M_COUNT;
					st_nxt.phase = P_FIRST;
					st_nxt.accum = 20'd0;
				end else if (is_letter) begin
					st_nxt.mode      = M_INLINE;
					st_nxt.word_open = 1'b1;
					res.event_res    = EV_IN_START;
					res.data_byte    = in_byte;
				end else begin
					res.event_res = EV_ERROR;
				end
			end
			M_INLINE: begin
				if (in_byte == CH_CR) begin
					res.event_res = EV_NONE;
				end else if (in_byte == CH_LF) begin
					res.event_res    = st.word_open ? EV_ARG_CMD : EV_CMD_END;
					st_nxt.mode      = M_START;
					st_nxt.phase     = P_FIRST;
					st_nxt.word_open = 1'b0;
				end else if (is_space) begin
					if (st.word_open) begin
						res.event_res    = EV_ARG_END;
						st_nxt.word_open = 1'b0;
					end
				end else begin
					res.event_res    = EV_DATA;
					res.data_byte    = in_byte;
					st_nxt.word_open = 1'b1;
				end
			end
			M_COUNT, M_LENGTH: begin
				st_nxt.phase = num_phase;
				st_nxt.accum = num_accum;
				if (nres == N_DONE) begin
					if (st.mode == M_COUNT) begin
						st_nxt.args_total = num_accum[15:0];
						st_nxt.args_done  = 16'd0;
						st_nxt.mode       = M_DOLLAR;
						res.event_res     = EV_MB_START;
						res.count         = {4'd0, num_accum[15:0]};
					end else begin
						st_nxt.bytes_left = num_accum;
						st_nxt.mode       = M_DATA;
						res.event_res     = EV_ARG_HDR;
						res.count         = num_accum;
					end
				end else if (nres == N_FAIL) begin
					res.event_res = EV_ERROR;
				end
			end
			M_DOLLAR: begin
				if (in_byte == CH_DOLLAR) begin
					st_nxt.mode  = M_LENGTH;
					st_nxt.phase = P_FIRST;
					st_nxt.accum = 20'd0;
				end else begin
					res.event_res = EV_ERROR;
				end
			end
			M_DATA: begin
				if (st.bytes_left != 20'd0) begin
					st_nxt.bytes_left = st.bytes_left - 20'd1;
					res.event_res     = EV_DATA;
					res.data_byte     = in_byte;
				end else if (in_byte == CH_CR) begin
					st_nxt.mode = M_DATA_CR;
				end else if (in_byte == CH_LF) begin
					st_nxt.args_done = done_inc;
					if (done_inc == st.args_total) begin
						res.event_res = EV_ARG_CMD;
						st_nxt.mode   = M_START;
						st_nxt.phase  = P_FIRST;
					end else begin
						res.event_res = EV_ARG_END;
						st_nxt.mode   = M_DOLLAR;
					end
				end else begin
					res.event_res = EV_ERROR;
				end
			end
			M_DATA_CR: begin
				if (in_byte == CH_LF) begin
					st_nxt.args_done = done_inc;
					if (done_inc == st.args_total) begin
						res.event_res = EV_ARG_CMD;
						st_nxt.mode   = M_START;
						st_nxt.phase  = P_FIRST;
					end else begin
						res.event_res = EV_ARG_END;
						st_nxt.mode   = M_DOLLAR;
					end
				end else begin
					res.event_res = EV_ERROR;
				end
			end
			default: begin
				res.event_res = EV_ERROR;
			end
		endcase
		if (res.event_res == EV_ERROR) begin
			st_nxt.mode      = M_START;
			st_nxt.phase     = P_FIRST;
			st_nxt.word_open = 1'b0;
		end
	end

endmodule

@@ hdl/resp_command_stream_parser.sv @@
// Top level of the request stream parser: input register, parse step, result register.
// An accepted byte is held in the input register; its event is then registered into the result register for the output.
// Throughput: one byte per cycle while results are taken; the parse state updates once per byte.
// A stalled result holds the parse step, and once the input register is full the input stalls.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to start.
module resp_command_stream_parser import rcsp_pkg::*; #(
	parameter int MAX_ARGS    = 65535,
	parameter int MAX_ARG_LEN = 1048575
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // event_res[3:0], data_byte[11:4], count[31:12]
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic       advance;
	logic       take_in;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	rcsp_step #(
		.MAX_ARGS    (MAX_ARGS),
		.MAX_ARG_LEN (MAX_ARG_LEN)
	) u_step (
		.st      (state_q),
		.in_byte (byte_s1),
		.st_nxt  (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.count, res_s2.data_byte, res_s2.event_res};

endmodule
